/* hw/rtl/assert_macros.svh */
// Assertion helpers for the RTL file that checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_SAME(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("assertion failed");

`endif

/* hw/rtl/dpbp_pkg.sv */
package dpbp_pkg;

   localparam int QUOT_BITS = 32;
   localparam int COORD_OUT_BITS = 29;

   localparam logic [2:0] CSR_FOCAL_X = 3'd0;
   localparam logic [2:0] CSR_FOCAL_Y = 3'd1;
   localparam logic [2:0] CSR_CENTER_X = 3'd2;
   localparam logic [2:0] CSR_CENTER_Y = 3'd3;
   localparam logic [2:0] CSR_NEAR_LIMIT = 3'd4;
   localparam logic [2:0] CSR_FAR_LIMIT = 3'd5;

   // One axis of a division in flight: partial remainder and the word that
   // holds the untouched numerator bits on top and quotient bits below.
   typedef struct packed {
      logic [15:0] rem;
      logic [QUOT_BITS-1:0] numq;
      logic neg;
      logic zero;
   } axis_type;

   typedef struct packed {
      axis_type ax;
      axis_type ay;
      logic [15:0] z;
      logic [23:0] color;
   } lane_type;

   // One restoring division step.
   function automatic axis_type div_step(input axis_type a, input logic [15:0] focal);
      logic [16:0] trial;
      logic take;
      axis_type r;
      trial = {a.rem, a.numq[QUOT_BITS-1]};
      take = (trial >= {1'b0, focal});
      r = a;
      r.rem = take ? 16'(trial - {1'b0, focal}) : trial[15:0];
      r.numq = {a.numq[QUOT_BITS-2:0], take};
      return r;
   endfunction

endpackage

/* hw/rtl/dpbp_div_cell.sv */
module dpbp_div_cell (
   input  logic clock,
   input  logic reset,
   input  logic [15:0] focal_x,
   input  logic [15:0] focal_y,
   input  logic in_valid,
   input  dpbp_pkg::lane_type in_data,
   output logic in_ready,
   output logic out_valid,
   output dpbp_pkg::lane_type out_data,
   input  logic out_ready
);

   logic valid_ff;
   dpbp_pkg::lane_type data_ff, data_in;

   // The cell may load whenever it is empty or its content moves on.
   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      data_in = in_data;
      data_in.ax = dpbp_pkg::div_step(in_data.ax, focal_x);
      data_in.ay = dpbp_pkg::div_step(in_data.ay, focal_y);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data = data_ff;

endmodule

/* hw/rtl/depth_pixel_back_projection.sv */
// Back-projects RGB-D pixels through a pinhole camera model into points in
// millimetres: Z is the depth, X = (column*16 - center_x) * Z / focal_x and
// Y = (row*16 - center_y) * Z / focal_y, truncated toward zero and saturated to
// 29-bit two's complement. A pixel with depth at or below near_limit or above
// far_limit gives no point. The block takes one request per clock while the
// result side does not stall. Stage 0 forms the offsets from the principal
// point, stage 1 multiplies them by the depth, a row of 32 division cells
// produces one quotient bit per cell for both axes at once, and the last
// cell feeds the saturation logic in front of the result register. Every stage
// holds its request while the next one is full, so back-pressure on the result
// side stalls only the stages that are occupied.
`include "assert_macros.svh"

module depth_pixel_back_projection #(
   parameter int COORD_BITS = 12
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [11:0] req_column,
   input  logic [11:0] req_row_index,
   input  logic [15:0] req_depth_mm,
   input  logic [7:0] req_red,
   input  logic [7:0] req_green,
   input  logic [7:0] req_blue,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic signed [28:0] rsp_x_mm,
   output logic signed [28:0] rsp_y_mm,
   output logic [15:0] rsp_z_mm,
   output logic [23:0] rsp_packed_color,
   input  logic psel,
   input  logic penable,
   input  logic pwrite,
   input  logic [4:0] paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic pready
);

   localparam int QB = dpbp_pkg::QUOT_BITS;
   // Column and row bits above COORD_BITS are ignored.
   localparam logic [11:0] COORD_MASK =
      (COORD_BITS >= 12) ? 12'hFFF : 12'((1 << COORD_BITS) - 1);
   localparam logic [QB-1:0] POS_LIMIT = QB'((1 << 28) - 1);
   localparam logic [QB-1:0] NEG_LIMIT = QB'(1 << 28);

   // Configuration registers.
   logic [15:0] focal_x_ff, focal_y_ff, center_x_ff, center_y_ff, near_ff, far_ff;
   logic csr_write;

   assign pready = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         focal_x_ff <= 16'd8566;
         focal_y_ff <= 16'd8627;
         center_x_ff <= 16'd5122;
         center_y_ff <= 16'd3962;
         near_ff <= 16'd100;
         far_ff <= 16'd6000;
      end else if (csr_write) begin
         case (paddr[4:2])
            dpbp_pkg::CSR_FOCAL_X: focal_x_ff <= pwdata[15:0];
            dpbp_pkg::CSR_FOCAL_Y: focal_y_ff <= pwdata[15:0];
            dpbp_pkg::CSR_CENTER_X: center_x_ff <= pwdata[15:0];
            dpbp_pkg::CSR_CENTER_Y: center_y_ff <= pwdata[15:0];
            dpbp_pkg::CSR_NEAR_LIMIT: near_ff <= pwdata[15:0];
            dpbp_pkg::CSR_FAR_LIMIT: far_ff <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[4:2])
         dpbp_pkg::CSR_FOCAL_X: prdata = {16'd0, focal_x_ff};
         dpbp_pkg::CSR_FOCAL_Y: prdata = {16'd0, focal_y_ff};
         dpbp_pkg::CSR_CENTER_X: prdata = {16'd0, center_x_ff};
         dpbp_pkg::CSR_CENTER_Y: prdata = {16'd0, center_y_ff};
         dpbp_pkg::CSR_NEAR_LIMIT: prdata = {16'd0, near_ff};
         dpbp_pkg::CSR_FAR_LIMIT: prdata = {16'd0, far_ff};
         default: prdata = 32'd0;
      endcase
   end

   // Stage 0: range check and signed offsets from the principal point.
   // Pixels out of range never enter the pipeline.
   logic s0_valid_ff, s0_ready, in_range;
   logic [15:0] s0_dx_ff, s0_dy_ff, s0_z_ff;
   logic s0_negx_ff, s0_negy_ff;
   logic [23:0] s0_color_ff;
   logic [15:0] scaled_x, scaled_y;
   logic negx, negy;

   assign in_range = (req_depth_mm > near_ff) && (req_depth_mm <= far_ff);
   assign scaled_x = {req_column & COORD_MASK, 4'd0};
   assign scaled_y = {req_row_index & COORD_MASK, 4'd0};
   assign negx = scaled_x < center_x_ff;
   assign negy = scaled_y < center_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s0_valid_ff <= req_valid && in_range;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready) begin
         s0_dx_ff <= negx ? 16'(center_x_ff - scaled_x) : 16'(scaled_x - center_x_ff);
         s0_dy_ff <= negy ? 16'(center_y_ff - scaled_y) : 16'(scaled_y - center_y_ff);
         s0_negx_ff <= negx;
         s0_negy_ff <= negy;
         s0_z_ff <= req_depth_mm;
         s0_color_ff <= {req_red, req_green, req_blue};
      end
   end

   // Stage 1: numerators. The depth is at least one here, so a numerator is
   // zero exactly when its offset is zero.
   logic s1_valid_ff, s1_ready;
   dpbp_pkg::lane_type s1_data_ff;

   logic [QB:0] chain_valid, chain_ready;
   dpbp_pkg::lane_type chain_data [QB+1];

   assign req_ready = !s0_valid_ff || s0_ready;
   assign s0_ready = !s1_valid_ff || s1_ready;
   assign s1_ready = chain_ready[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s0_ready) begin
         s1_valid_ff <= s0_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s0_ready) begin
         s1_data_ff.ax.rem <= 16'd0;
         s1_data_ff.ax.numq <= QB'({16'd0, s0_dx_ff} * {16'd0, s0_z_ff});
         s1_data_ff.ax.neg <= s0_negx_ff;
         s1_data_ff.ax.zero <= (s0_dx_ff == 16'd0);
         s1_data_ff.ay.rem <= 16'd0;
         s1_data_ff.ay.numq <= QB'({16'd0, s0_dy_ff} * {16'd0, s0_z_ff});
         s1_data_ff.ay.neg <= s0_negy_ff;
         s1_data_ff.ay.zero <= (s0_dy_ff == 16'd0);
         s1_data_ff.z <= s0_z_ff;
         s1_data_ff.color <= s0_color_ff;
      end
   end

   assign chain_valid[0] = s1_valid_ff;
   assign chain_data[0] = s1_data_ff;

   // Division row: each cell retires one quotient bit per axis.
   for (genvar k = 0; k < QB; k++) begin : g_cell
      dpbp_div_cell u_cell (
         .clock(clock),
         .reset(reset),
         .focal_x(focal_x_ff),
         .focal_y(focal_y_ff),
         .in_valid(chain_valid[k]),
         .in_data(chain_data[k]),
         .in_ready(chain_ready[k]),
         .out_valid(chain_valid[k+1]),
         .out_data(chain_data[k+1]),
         .out_ready(chain_ready[k+1])
      );
   end

   // Output stage: saturation and sign. A zero focal length leaves an all-ones
   // quotient, which saturates the same way as an overflow.
   logic rsp_valid_ff;
   logic [28:0] x_ff, y_ff, x_in, y_in;
   logic [15:0] z_ff;
   logic [23:0] color_ff;

   function automatic logic [28:0] finish(input dpbp_pkg::axis_type a,
                                          input logic [QB-1:0] pos_lim,
                                          input logic [QB-1:0] neg_lim);
      logic [QB-1:0] mag;
      logic [28:0] r;
      if (a.zero) begin
         r = 29'd0;
      end else if (a.neg) begin
         mag = (a.numq > neg_lim) ? neg_lim : a.numq;
         r = 29'(29'd0 - mag[28:0]);
      end else begin
         mag = (a.numq > pos_lim) ? pos_lim : a.numq;
         r = mag[28:0];
      end
      return r;
   endfunction

   assign chain_ready[QB] = !rsp_valid_ff || rsp_ready;
   assign x_in = finish(chain_data[QB].ax, POS_LIMIT, NEG_LIMIT);
   assign y_in = finish(chain_data[QB].ay, POS_LIMIT, NEG_LIMIT);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (chain_ready[QB]) begin
         rsp_valid_ff <= chain_valid[QB];
      end
   end

   always_ff @(posedge clock) begin
      if (chain_ready[QB]) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= chain_data[QB].z;
         color_ff <= chain_data[QB].color;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_x_mm = x_ff;
   assign rsp_y_mm = y_ff;
   assign rsp_z_mm = z_ff;
   assign rsp_packed_color = color_ff;

   // A waiting result is held until it is taken.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_z_mm))
   // Only in-range depths reach the result port.
   `ASSERT_SAME(a_rsp_range, clock, reset, rsp_valid, rsp_z_mm > near_ff && rsp_z_mm <= far_ff)
   // An accepted in-range pixel always lands in the first stage.
   `ASSERT_NEXT(a_s0_load, clock, reset, req_valid && req_ready && in_range, s0_valid_ff)

endmodule
